/* rtl/urm_pkg.sv */
// Shared types and constants for the ultrasonic ranger with median filter.
// Holds the phase enum, register indexes, reset values and the result item layout.
// No dependencies; every other file refers to it by scoped names.
`default_nettype none

package urm_pkg;

	// Measurement phases of the ranging sequencer.
	typedef enum logic [2:0] {
		PH_TRIG_LOW  = 3'd0,
		PH_TRIG_HIGH = 3'd1,
		PH_ECHO      = 3'd2,
		PH_READ_GAP  = 3'd3,
		PH_BATCH_GAP = 3'd4
	} phase_t;

	// Requests from the sequencer to the sorted store.
	typedef struct packed {
		logic insert;
		logic clear;
	} sort_ctrl_t;

	// Configuration register indexes.
	localparam logic [2:0] REG_SAMPLES      = 3'd0;
	localparam logic [2:0] REG_ECHO_TIMEOUT = 3'd1;
	localparam logic [2:0] REG_MIN_DIST     = 3'd2;
	localparam logic [2:0] REG_MAX_DIST     = 3'd3;
	localparam logic [2:0] REG_READ_GAP     = 3'd4;
	localparam logic [2:0] REG_BATCH_GAP    = 3'd5;
	localparam logic [2:0] REG_LOSS_TIMEOUT = 3'd6;

	// Register reset values.
	localparam logic [3:0]  RST_SAMPLES      = 4'd5;
	localparam logic [15:0] RST_ECHO_TIMEOUT = 16'd30000;
	localparam logic [16:0] RST_MIN_DIST     = 17'd512;
	localparam logic [16:0] RST_MAX_DIST     = 17'd102400;
	localparam logic [15:0] RST_READ_GAP     = 16'd20000;
	localparam logic [19:0] RST_BATCH_GAP    = 20'd300000;
	localparam logic [23:0] RST_LOSS_TIMEOUT = 24'd10000000;

	// Timing constants in ticks.
	localparam logic [23:0] TRIG_LOW_TICKS  = 24'd2;
	localparam logic [23:0] TRIG_HIGH_TICKS = 24'd10;
	localparam logic [23:0] TICKS_MAX       = 24'hFFFFFF;

	// Distance scaling: each microsecond of echo is 4456/1024 units of 1/256 cm.
	localparam int          ACC_W      = 29;
	localparam logic [28:0] DIST_STEP  = 29'd4456;
	localparam int          DIST_SHIFT = 10;
	localparam int          DIST_W     = 17;
	localparam logic [15:0] WIDTH_MAX  = 16'hFFFF;
	localparam logic [15:0] FAIL_MAX   = 16'hFFFF;

	// Result item layout in m_tdata, lowest bit first.
	localparam int OUT_TRIG     = 0;
	localparam int OUT_READY    = 1;
	localparam int OUT_DIST_LSB = 2;
	localparam int OUT_OK       = 19;
	localparam int OUT_NV_LSB   = 20;
	localparam int OUT_FAIL_LSB = 24;
	localparam int OUT_CONN     = 40;
	localparam int OUT_USED     = 41;
	localparam int OUT_DATA_W   = 48;

endpackage

`default_nettype wire

/* rtl/urm_sorter.sv */
// Sorted sample store of the ranger: inserts one distance per request in order.
// Gives the median at index count/2 and the fill count of the current batch.
// Depends on urm_pkg for the control struct and the distance width.
`default_nettype none

module urm_sorter #(
	parameter int MAX_SAMPLES = 8,
	parameter int CNT_W       = $clog2(MAX_SAMPLES + 1),
	parameter int IDX_W       = (MAX_SAMPLES > 1) ? $clog2(MAX_SAMPLES) : 1
) (
	input  wire                          clk,
	input  wire                          arst_n,
	input  urm_pkg::sort_ctrl_t          ctrl,
	input  wire  [urm_pkg::DIST_W-1:0]   value,
	output logic [CNT_W-1:0]             count,
	output logic [urm_pkg::DIST_W-1:0]   median
);

	logic [urm_pkg::DIST_W-1:0] store_q [MAX_SAMPLES];
	logic [urm_pkg::DIST_W-1:0] store_d [MAX_SAMPLES];
	logic [MAX_SAMPLES-1:0]     gt;
	logic [CNT_W-1:0]           count_q;
	logic                       full;

	assign full = (count_q >= CNT_W'(MAX_SAMPLES));

	// Entries of the filled prefix that sort after the new value.
	always_comb begin
		for (int j = 0; j < MAX_SAMPLES; j++) begin
			gt[j] = (CNT_W'(j) < count_q) && (store_q[j] > value);
		end
	end

	// Each slot takes its lower neighbour, the new value, or keeps its own.
	for (genvar j = 0; j < MAX_SAMPLES; j++) begin : g_slot
		if (j == 0) begin : g_first
			assign store_d[j] = (gt[j] || (count_q == CNT_W'(j))) ? value : store_q[j];
		end else begin : g_rest
			assign store_d[j] = gt[j-1] ? store_q[j-1] :
				((gt[j] || (count_q == CNT_W'(j))) ? value : store_q[j]);
		end
	end

	// Store contents carry no reset; only the filled prefix is ever used.
	always_ff @(posedge clk) begin
		if (ctrl.insert && !full) begin
			store_q <= store_d;
		end
	end

	// Fill count of the batch in progress.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			count_q <= '0;
		end else if (ctrl.clear) begin
			count_q <= '0;
		end else if (ctrl.insert && !full) begin
			count_q <= count_q + CNT_W'(1);
		end
	end

	assign count  = count_q;
	assign median = store_q[IDX_W'(count_q >> 1)];

endmodule

`default_nettype wire

/* rtl/ultrasonic_ranger_median_top.sv */
// Top level of the ultrasonic time-of-flight ranger with batch median filter.
// Holds the configuration registers, the ranging sequencer and the result register.
// Depends on urm_pkg and instantiates urm_sorter.
//
// Channel   Direction  Width  Contents
// s_*       in         8      one echo level sample per microsecond tick
// m_*       out        48     trigger level, batch result and link status for that tick
// cfg_*     in         24     register write, index 0 to 6, no read-back
//
// Each item's result is loaded into the result register when the item is accepted;
// with m_tready high an item is accepted every cycle.
// The sequencer update and the sorted insertion are both combinational.
// Reset clears the sequencer, counters and fill count; the sample store is not cleared.
// A stalled result holds s_tready low until it is taken; no state advances meanwhile.
`default_nettype none

module ultrasonic_ranger_median_top #(
	parameter int MAX_SAMPLES = 8
) (
	input  wire         clk,
	input  wire         arst_n,
	// s_tdata: [0] echo_level, [7:1] zero
	input  wire         s_tvalid,
	output logic        s_tready,
	input  wire  [7:0]  s_tdata,
	// m_tdata: [0] trigger, [1] result_ready, [18:2] distance_q8, [19] distance_ok,
	// [23:20] valid_readings, [39:24] failed_batches, [40] connected, [47:41] zero
	output logic        m_tvalid,
	input  wire         m_tready,
	output logic [47:0] m_tdata,
	input  wire         cfg_we,
	input  wire  [2:0]  cfg_index,
	input  wire  [23:0] cfg_data
);

	localparam int CNT_W = $clog2(MAX_SAMPLES + 1);

	// Configuration registers.
	logic [3:0]  samples_q;
	logic [15:0] echo_timeout_q;
	logic [16:0] min_dist_q;
	logic [16:0] max_dist_q;
	logic [15:0] read_gap_q;
	logic [19:0] batch_gap_q;
	logic [23:0] loss_timeout_q;

	// Sequencer state.
	urm_pkg::phase_t phase_q, phase_d;
	logic [23:0] phase_ticks_q, phase_ticks_d, pt_inc;
	logic        seen_q, seen_d;
	logic [15:0] width_q, width_d;
	logic [urm_pkg::ACC_W-1:0] acc_q, acc_d;
	logic [3:0]  ridx_q, ridx_d;
	logic [15:0] failed_q, failed_d;
	logic        conn_q, conn_d;
	logic [23:0] tsv_q, tsv_d, tsv_inc;

	// Per-item results and helpers.
	logic        trig, ready, ok, finish, use_width, in_range, accept;
	logic [16:0] med_dist;
	logic [3:0]  nvalid;
	logic [18:0] dist_raw;
	logic [4:0]  spb_ext, batch_n;
	logic        echo;
	urm_pkg::sort_ctrl_t sort_req, sort_ctrl;
	logic [CNT_W-1:0]    count;
	logic [16:0]         median;

	// Result register.
	logic        out_valid_q;
	logic [47:0] out_data_q;

	assign accept   = s_tvalid && s_tready;
	assign s_tready = !out_valid_q || m_tready;
	assign echo     = s_tdata[0];

	// Configuration writes; indexes beyond the list are ignored.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			samples_q      <= urm_pkg::RST_SAMPLES;
			echo_timeout_q <= urm_pkg::RST_ECHO_TIMEOUT;
			min_dist_q     <= urm_pkg::RST_MIN_DIST;
			max_dist_q     <= urm_pkg::RST_MAX_DIST;
			read_gap_q     <= urm_pkg::RST_READ_GAP;
			batch_gap_q    <= urm_pkg::RST_BATCH_GAP;
			loss_timeout_q <= urm_pkg::RST_LOSS_TIMEOUT;
		end else if (cfg_we) begin
			unique case (cfg_index)
				urm_pkg::REG_SAMPLES:      samples_q      <= cfg_data[3:0];
				urm_pkg::REG_ECHO_TIMEOUT: echo_timeout_q <= cfg_data[15:0];
				urm_pkg::REG_MIN_DIST:     min_dist_q     <= cfg_data[16:0];
				urm_pkg::REG_MAX_DIST:     max_dist_q     <= cfg_data[16:0];
				urm_pkg::REG_READ_GAP:     read_gap_q     <= cfg_data[15:0];
				urm_pkg::REG_BATCH_GAP:    batch_gap_q    <= cfg_data[19:0];
				urm_pkg::REG_LOSS_TIMEOUT: loss_timeout_q <= cfg_data;
				default: begin
				end
			endcase
		end
	end

	// Batch size clamped to the range one to MAX_SAMPLES.
	assign spb_ext = {1'b0, samples_q};
	assign batch_n = (samples_q == 4'd0) ? 5'd1 :
		((spb_ext > 5'(MAX_SAMPLES)) ? 5'(MAX_SAMPLES) : spb_ext);

	// The distance accumulator follows the echo width, so no multiplier is needed.
	assign dist_raw = acc_q[urm_pkg::ACC_W-1:urm_pkg::DIST_SHIFT];
	assign in_range = (width_q != 16'd0) && (dist_raw >= {2'b00, min_dist_q})
		&& (dist_raw <= {2'b00, max_dist_q});

	assign pt_inc  = (phase_ticks_q == urm_pkg::TICKS_MAX) ? phase_ticks_q
		: phase_ticks_q + 24'd1;
	assign tsv_inc = (tsv_q == urm_pkg::TICKS_MAX) ? tsv_q : tsv_q + 24'd1;

	// Sequencer next state and the result item of this tick.
	always_comb begin
		phase_d       = phase_q;
		phase_ticks_d = pt_inc;
		seen_d        = seen_q;
		width_d       = width_q;
		acc_d         = acc_q;
		ridx_d        = ridx_q;
		failed_d      = failed_q;
		conn_d        = conn_q;
		tsv_d         = tsv_inc;
		sort_req      = '0;
		trig          = 1'b0;
		ready         = 1'b0;
		med_dist      = '0;
		ok            = 1'b0;
		nvalid        = '0;
		finish        = 1'b0;
		use_width     = 1'b0;
		unique case (phase_q)
			urm_pkg::PH_TRIG_LOW: begin
				if (pt_inc >= urm_pkg::TRIG_LOW_TICKS) begin
					phase_d       = urm_pkg::PH_TRIG_HIGH;
					phase_ticks_d = '0;
				end
			end
			urm_pkg::PH_TRIG_HIGH: begin
				trig = 1'b1;
				if (pt_inc >= urm_pkg::TRIG_HIGH_TICKS) begin
					seen_d        = 1'b0;
					width_d       = '0;
					acc_d         = '0;
					phase_d       = urm_pkg::PH_ECHO;
					phase_ticks_d = '0;
				end
			end
			urm_pkg::PH_ECHO: begin
				if (echo) begin
					seen_d = 1'b1;
					if (width_q != urm_pkg::WIDTH_MAX) begin
						width_d = width_q + 16'd1;
						acc_d   = acc_q + urm_pkg::DIST_STEP;
					end
				end
				// A falling edge ends the pulse; otherwise the timeout fails the reading.
				if (!echo && seen_q) begin
					finish    = 1'b1;
					use_width = 1'b1;
				end else if (pt_inc >= {8'd0, echo_timeout_q}) begin
					finish = 1'b1;
				end
				if (finish) begin
					sort_req.insert = use_width && in_range;
					ridx_d          = ridx_q + 4'd1;
					seen_d          = 1'b0;
					width_d         = '0;
					acc_d           = '0;
					phase_d         = urm_pkg::PH_READ_GAP;
					phase_ticks_d   = '0;
				end
			end
			urm_pkg::PH_READ_GAP: begin
				if (pt_inc >= {8'd0, read_gap_q}) begin
					phase_ticks_d = '0;
					if ({1'b0, ridx_q} >= batch_n) begin
						// End of batch: report the median or count a failure.
						ready  = 1'b1;
						nvalid = 4'(count);
						if (count != '0) begin
							ok       = 1'b1;
							med_dist = median;
							failed_d = '0;
							conn_d   = 1'b1;
							tsv_d    = '0;
						end else begin
							if (failed_q != urm_pkg::FAIL_MAX) begin
								failed_d = failed_q + 16'd1;
							end
							if (conn_q && (tsv_inc > loss_timeout_q)) begin
								conn_d = 1'b0;
							end
						end
						ridx_d         = '0;
						sort_req.clear = 1'b1;
						phase_d        = urm_pkg::PH_BATCH_GAP;
					end else begin
						phase_d = urm_pkg::PH_TRIG_LOW;
					end
				end
			end
			urm_pkg::PH_BATCH_GAP: begin
				if (pt_inc >= {4'd0, batch_gap_q}) begin
					phase_d       = urm_pkg::PH_TRIG_LOW;
					phase_ticks_d = '0;
				end
			end
			default: begin
				phase_d       = urm_pkg::PH_TRIG_LOW;
				phase_ticks_d = '0;
			end
		endcase
	end

	// Sequencer state advances once per accepted item.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q       <= urm_pkg::PH_TRIG_LOW;
			phase_ticks_q <= '0;
			seen_q        <= 1'b0;
			width_q       <= '0;
			acc_q         <= '0;
			ridx_q        <= '0;
			failed_q      <= '0;
			conn_q        <= 1'b0;
			tsv_q         <= '0;
		end else if (accept) begin
			phase_q       <= phase_d;
			phase_ticks_q <= phase_ticks_d;
			seen_q        <= seen_d;
			width_q       <= width_d;
			acc_q         <= acc_d;
			ridx_q        <= ridx_d;
			failed_q      <= failed_d;
			conn_q        <= conn_d;
			tsv_q         <= tsv_d;
		end
	end

	assign sort_ctrl.insert = accept && sort_req.insert;
	assign sort_ctrl.clear  = accept && sort_req.clear;

	urm_sorter #(
		.MAX_SAMPLES(MAX_SAMPLES)
	) u_sorter (
		.clk    (clk),
		.arst_n (arst_n),
		.ctrl   (sort_ctrl),
		.value  (dist_raw[16:0]),
		.count  (count),
		.median (median)
	);

	// Result register: loaded on accept, emptied when the item is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (m_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {{(urm_pkg::OUT_DATA_W - urm_pkg::OUT_USED){1'b0}},
				conn_d, failed_d, nvalid, ok, med_dist, ready, trig};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule

`default_nettype wire

/* rtl/urm_checker.sv */
// Port-level checks on the ultrasonic ranger top level, attached by bind.
// Depends on urm_pkg for the result item layout.
`default_nettype none

module urm_checker (
	input wire        clk,
	input wire        arst_n,
	input wire        m_tvalid,
	input wire        m_tready,
	input wire [47:0] m_tdata
);

	logic        r_trig, r_ready, r_ok, r_conn;
	logic [16:0] r_dist;
	logic [3:0]  r_nv;
	logic [15:0] r_fail;

	assign r_trig  = m_tdata[urm_pkg::OUT_TRIG];
	assign r_ready = m_tdata[urm_pkg::OUT_READY];
	assign r_ok    = m_tdata[urm_pkg::OUT_OK];
	assign r_conn  = m_tdata[urm_pkg::OUT_CONN];
	assign r_dist  = m_tdata[urm_pkg::OUT_DIST_LSB +: 17];
	assign r_nv    = m_tdata[urm_pkg::OUT_NV_LSB +: 4];
	assign r_fail  = m_tdata[urm_pkg::OUT_FAIL_LSB +: 16];

	// A stalled result item holds.
	a_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
		else $error("result item changed while stalled");

	// A good distance only comes with a batch result.
	a_ok_ready: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_ok |-> r_ready)
		else $error("distance_ok outside a batch result");

	// Between batch results the batch fields are zero.
	a_idle_zero: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && !r_ready |-> (r_dist == 17'd0) && (r_nv == 4'd0))
		else $error("batch fields set outside a batch result");

	// A good batch clears the failure count and marks the sensor connected.
	a_ok_status: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_ok |-> (r_fail == 16'd0) && r_conn)
		else $error("status not updated by a good batch");

	// The trigger is low on the tick a batch completes.
	a_ready_trig: assert property (@(posedge clk) disable iff (!arst_n)
		m_tvalid && r_ready |-> !r_trig)
		else $error("trigger high on a batch result");

endmodule

bind ultrasonic_ranger_median_top urm_checker u_urm_checker (
	.clk      (clk),
	.arst_n   (arst_n),
	.m_tvalid (m_tvalid),
	.m_tready (m_tready),
	.m_tdata  (m_tdata)
);

`default_nettype wire

/* dv/testbench.sv */
// Self-checking testbench for the ultrasonic ranger with batch median filter.
// A scoreboard class predicts every tick's result item; plain tasks drive the streams and registers.
// Depends on urm_pkg and ultrasonic_ranger_median_top.
`timescale 1ns / 100ps

module testbench;

	localparam int STORE_DEPTH = 8;
	localparam int STUCK_LIMIT = 2000;
	localparam int REPORT_MAX  = 40;

	// One predicted result item, one field per output.
	typedef struct packed {
		logic        trig;
		logic        ready;
		logic [16:0] distance;
		logic        ok;
		logic [3:0]  nvalid;
		logic [15:0] failed;
		logic        conn;
	} tick_result_t;

	// How the echo line behaves during one reading.
	typedef enum logic [1:0] {
		LINE_PULSE,
		LINE_STUCK,
		LINE_NOISE
	} line_mode_t;

	// Tracks the ranger state and holds the result items still to come.
	class range_scoreboard;
		logic [3:0]  batch_cfg;
		logic [15:0] echo_limit;
		logic [16:0] dist_lo;
		logic [16:0] dist_hi;
		logic [15:0] read_gap;
		logic [19:0] batch_gap;
		logic [23:0] loss_limit;

		urm_pkg::phase_t ph;
		logic [23:0] ph_ticks;
		bit          seen;
		logic [15:0] width;
		logic [3:0]  read_idx;
		logic [16:0] store [STORE_DEPTH];
		logic [3:0]  n_valid;
		logic [15:0] n_failed;
		bit          link;
		logic [23:0] since_valid;

		tick_result_t ticks_due[$];
		int errors;

		function new();
			batch_cfg   = 4'd5;
			echo_limit  = 16'd30000;
			dist_lo     = 17'd512;
			dist_hi     = 17'd102400;
			read_gap    = 16'd20000;
			batch_gap   = 20'd300000;
			loss_limit  = 24'd10000000;
			ph          = urm_pkg::PH_TRIG_LOW;
			ph_ticks    = '0;
			seen        = 1'b0;
			width       = '0;
			read_idx    = '0;
			n_valid     = '0;
			n_failed    = '0;
			link        = 1'b0;
			since_valid = '0;
			errors      = 0;
		endfunction

		function void write_reg(logic [2:0] idx, logic [23:0] v);
			case (idx)
				urm_pkg::REG_SAMPLES:      batch_cfg  = v[3:0];
				urm_pkg::REG_ECHO_TIMEOUT: echo_limit = v[15:0];
				urm_pkg::REG_MIN_DIST:     dist_lo    = v[16:0];
				urm_pkg::REG_MAX_DIST:     dist_hi    = v[16:0];
				urm_pkg::REG_READ_GAP:     read_gap   = v[15:0];
				urm_pkg::REG_BATCH_GAP:    batch_gap  = v[19:0];
				urm_pkg::REG_LOSS_TIMEOUT: loss_limit = v[23:0];
				default: ;
			endcase
		endfunction

		function int pending();
			return ticks_due.size();
		endfunction

		function void enter(urm_pkg::phase_t p);
			ph = p;
			ph_ticks = '0;
		endfunction

		// A batch size of zero counts as one; anything above the store depth is clipped.
		function logic [3:0] readings_per_batch();
			if (batch_cfg == 4'd0) return 4'd1;
			if (batch_cfg > STORE_DEPTH) return 4'(STORE_DEPTH);
			return batch_cfg;
		endfunction

		// Converts the echo width and keeps the distance if it lies inside the window.
		function void end_reading(logic [15:0] w);
			int unsigned d;
			int i;
			d = (32'(w) * 32'd4456) >> 10;
			if (w != 16'd0 && d >= dist_lo && d <= dist_hi && n_valid < STORE_DEPTH) begin
				i = n_valid;
				while (i > 0 && store[i - 1] > d[16:0]) begin
					store[i] = store[i - 1];
					i--;
				end
				store[i] = d[16:0];
				n_valid++;
			end
			read_idx = read_idx + 4'd1;
			seen = 1'b0;
			width = '0;
			enter(urm_pkg::PH_READ_GAP);
		endfunction

		// Advances the prediction by one accepted echo item.
		function void echo_tick(bit echo);
			tick_result_t r;
			r = '0;
			if (since_valid != 24'hFFFFFF) since_valid++;
			if (ph_ticks != 24'hFFFFFF) ph_ticks++;
			case (ph)
				urm_pkg::PH_TRIG_LOW: begin
					if (ph_ticks >= 24'd2) enter(urm_pkg::PH_TRIG_HIGH);
				end
				urm_pkg::PH_TRIG_HIGH: begin
					r.trig = 1'b1;
					if (ph_ticks >= 24'd10) begin
						seen = 1'b0;
						width = '0;
						enter(urm_pkg::PH_ECHO);
					end
				end
				urm_pkg::PH_ECHO: begin
					if (echo) begin
						seen = 1'b1;
						if (width != 16'hFFFF) width++;
					end
					if (!echo && seen) end_reading(width);
					else if (ph_ticks >= echo_limit) end_reading(16'd0);
				end
				urm_pkg::PH_READ_GAP: begin
					if (ph_ticks >= read_gap) begin
						if (read_idx >= readings_per_batch()) begin
							r.ready = 1'b1;
							r.nvalid = n_valid;
							if (n_valid != 4'd0) begin
								r.ok = 1'b1;
								r.distance = store[n_valid >> 1];
								n_failed = '0;
								link = 1'b1;
								since_valid = '0;
							end else begin
								if (n_failed != 16'hFFFF) n_failed++;
								if (link && since_valid > loss_limit) link = 1'b0;
							end
							read_idx = '0;
							n_valid = '0;
							enter(urm_pkg::PH_BATCH_GAP);
						end else begin
							enter(urm_pkg::PH_TRIG_LOW);
						end
					end
				end
				urm_pkg::PH_BATCH_GAP: begin
					if (ph_ticks >= batch_gap) enter(urm_pkg::PH_TRIG_LOW);
				end
				default: enter(urm_pkg::PH_TRIG_LOW);
			endcase
			r.failed = n_failed;
			r.conn = link;
			ticks_due.push_back(r);
		endfunction

		function void check_field(string name, logic [31:0] want, logic [31:0] got);
			if (want !== got) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: %s expected %0h, actual %0h", $time, name, want, got);
			end
		endfunction

		// Compares one accepted result item with the oldest prediction.
		function void check_tick(logic [47:0] d);
			tick_result_t want;
			if (ticks_due.size() == 0) begin
				errors++;
				if (errors <= REPORT_MAX)
					$display("%0t: result item expected none, actual %h", $time, d);
				return;
			end
			want = ticks_due.pop_front();
			check_field("trigger", want.trig, d[urm_pkg::OUT_TRIG]);
			check_field("result_ready", want.ready, d[urm_pkg::OUT_READY]);
			check_field("distance_q8", want.distance,
				d[urm_pkg::OUT_DIST_LSB +: urm_pkg::DIST_W]);
			check_field("distance_ok", want.ok, d[urm_pkg::OUT_OK]);
			check_field("valid_readings", want.nvalid, d[urm_pkg::OUT_NV_LSB +: 4]);
			check_field("failed_batches", want.failed, d[urm_pkg::OUT_FAIL_LSB +: 16]);
			check_field("connected", want.conn, d[urm_pkg::OUT_CONN]);
			check_field("padding", 32'd0, d[47:urm_pkg::OUT_USED]);
		endfunction
	endclass

	logic        clk;
	logic        arst_n    = 1'b0;
	logic        s_tvalid  = 1'b0;
	logic        s_tready;
	logic [7:0]  s_tdata   = 8'd0;
	logic        m_tvalid;
	logic        m_tready  = 1'b0;
	logic [47:0] m_tdata;
	logic        cfg_we    = 1'b0;
	logic [2:0]  cfg_index = 3'd0;
	logic [23:0] cfg_data  = 24'd0;

	range_scoreboard sb;

	// Stimulus control, shared between the initial block and the clocked driver.
	int         items_to_send = 0;
	int         burst_left    = 0;
	int         gap_left      = 0;
	bit         drain_wait    = 1'b0;
	bit         quiet_mode    = 1'b0;
	bit         rx_stall      = 1'b0;
	int         rx_left       = 0;
	int         stuck_cycles  = 0;
	line_mode_t line_mode     = LINE_PULSE;
	int         lead_left     = 0;
	int         pulse_left    = 0;
	int         pulse_max     = 20;
	int         scripted[$];

	ultrasonic_ranger_median_top #(
		.MAX_SAMPLES(STORE_DEPTH)
	) u_top (
		.clk(clk),
		.arst_n(arst_n),
		.s_tvalid(s_tvalid),
		.s_tready(s_tready),
		.s_tdata(s_tdata),
		.m_tvalid(m_tvalid),
		.m_tready(m_tready),
		.m_tdata(m_tdata),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_data(cfg_data)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Chooses the echo level of the next item from the predicted phase.
	function bit next_echo();
		int pick;
		if (sb.ph == urm_pkg::PH_ECHO && sb.ph_ticks == 24'd0) begin
			// A new reading starts, so pick the shape of its echo.
			line_mode = LINE_PULSE;
			lead_left = $urandom_range(0, 4);
			if (scripted.size() != 0) begin
				pulse_left = scripted.pop_front();
			end else begin
				pick = $urandom_range(0, 9);
				pulse_left = $urandom_range(1, pulse_max);
				if (pick == 0) pulse_left = 0;
				else if (pick == 1) line_mode = LINE_STUCK;
				else if (pick == 2) line_mode = LINE_NOISE;
			end
		end
		if (sb.ph != urm_pkg::PH_ECHO || line_mode == LINE_NOISE)
			return 1'($urandom_range(0, 1));
		if (line_mode == LINE_STUCK) return 1'b1;
		if (lead_left > 0) begin
			lead_left--;
			return 1'b0;
		end
		if (pulse_left > 0) begin
			pulse_left--;
			return 1'b1;
		end
		return 1'b0;
	endfunction

	// Sender: bursts of items with random gaps, now and then waiting for the results to drain.
	task automatic drive_sender(input bit took);
		if (took) begin
			items_to_send--;
			if (burst_left > 0) burst_left--;
		end
		if (s_tvalid && !took) return;
		if (items_to_send == 0) begin
			s_tvalid <= 1'b0;
			return;
		end
		if (burst_left == 0) begin
			burst_left = $urandom_range(1, 48);
			gap_left = ($urandom_range(0, 3) == 0 || quiet_mode) ? 0 : $urandom_range(1, 8);
			drain_wait = !quiet_mode && ($urandom_range(0, 29) == 0);
		end
		if (gap_left > 0) begin
			gap_left--;
			s_tvalid <= 1'b0;
		end else if (drain_wait && sb.pending() != 0) begin
			s_tvalid <= 1'b0;
		end else begin
			drain_wait = 1'b0;
			s_tvalid <= 1'b1;
			s_tdata <= {7'd0, next_echo()};
		end
	endtask

	// Receiver: alternating ready stretches and short stalls.
	task automatic drive_receiver();
		if (quiet_mode) begin
			m_tready <= 1'b1;
			return;
		end
		if (rx_left == 0) begin
			rx_stall = !rx_stall;
			rx_left = rx_stall ? $urandom_range(1, 6) : $urandom_range(1, 40);
		end
		rx_left--;
		m_tready <= !rx_stall;
	endtask

	// Notes accepted items, checks results and drives both streams, all in one process.
	always @(posedge clk) begin
		if (arst_n) begin
			if (s_tvalid && s_tready) sb.echo_tick(s_tdata[0]);
			if (m_tvalid && m_tready) sb.check_tick(m_tdata);
			drive_sender(s_tvalid && s_tready);
			drive_receiver();
		end
	end

	// Watchdog: ends the run when no item moves on either side for too long.
	always @(posedge clk) begin
		if (arst_n && !(s_tvalid && s_tready) && !(m_tvalid && m_tready))
			stuck_cycles++;
		else
			stuck_cycles = 0;
		if (stuck_cycles >= STUCK_LIMIT) begin
			$display("%0t: no item moved for %0d cycles", $time, stuck_cycles);
			$display("DONE: errors detected");
			$finish;
		end
	end

	task automatic set_reg(input logic [2:0] idx, input logic [23:0] v);
		@(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= v;
		sb.write_reg(idx, v);
		@(posedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic configure(input logic [3:0] n, input logic [15:0] tmo,
			input logic [16:0] lo, input logic [16:0] hi, input logic [15:0] rgap,
			input logic [19:0] bgap, input logic [23:0] loss);
		set_reg(urm_pkg::REG_SAMPLES, 24'(n));
		set_reg(urm_pkg::REG_ECHO_TIMEOUT, 24'(tmo));
		set_reg(urm_pkg::REG_MIN_DIST, 24'(lo));
		set_reg(urm_pkg::REG_MAX_DIST, 24'(hi));
		set_reg(urm_pkg::REG_READ_GAP, 24'(rgap));
		set_reg(urm_pkg::REG_BATCH_GAP, 24'(bgap));
		set_reg(urm_pkg::REG_LOSS_TIMEOUT, loss);
	endtask

	// Sends n items, then waits until every result item has been taken.
	task automatic run_items(input int n, input bit quiet, input int pmax);
		@(negedge clk);
		quiet_mode = quiet;
		pulse_max = pmax;
		// A reading left open by the last phase is closed by one short pulse.
		line_mode = LINE_PULSE;
		lead_left = 0;
		pulse_left = 1;
		items_to_send = n;
		while (items_to_send != 0 || sb.pending() != 0) @(negedge clk);
		repeat (2) @(negedge clk);
	endtask

	initial begin
		int k;
		int pick;
		logic [3:0] n_sel;
		sb = new();
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;

		// Reset values: trigger sequence and the start of the first echo window.
		run_items(30, 1'b0, 20);

		// Shortest pulse, a silent line with a zero minimum, and short mixed pulses.
		configure(4'd3, 16'd120, 17'd0, 17'd131071, 16'd0, 20'd0, 24'd0);
		scripted = '{1, 0, 60, 2, 7, 3};
		run_items(300, 1'b0, 30);

		// Oversized batch size with descending widths to exercise the sorted insert.
		configure(4'd15, 16'd100, 17'd0, 17'd131071, 16'd2, 20'd3, 24'hFFFFFF);
		scripted = '{40, 35, 30, 25, 20, 15, 10, 5};
		run_items(340, 1'b0, 40);

		// Zero batch size and zero timeout, empty window: every batch fails and the link drops.
		configure(4'd0, 16'd0, 17'd131071, 17'd0, 16'd0, 20'd0, 24'd0);
		run_items(80, 1'b0, 10);

		// Longest loss timeout: failed batches keep the link up.
		configure(4'd1, 16'd60, 17'd10, 17'd200, 16'd3, 20'd2, 24'hFFFFFF);
		run_items(80, 1'b0, 40);

		// A long gap between readings with a short loss timeout.
		configure(4'd1, 16'd60, 17'd0, 17'd131071, 16'd60, 20'd0, 24'd50);
		run_items(130, 1'b1, 30);

		// Random settings, each phase starting wherever the last one left the sequencer.
		for (k = 0; k < 4; k++) begin
			pick = $urandom_range(0, 9);
			if (pick == 0) n_sel = 4'd0;
			else if (pick == 1) n_sel = 4'($urandom_range(8, 15));
			else n_sel = 4'($urandom_range(1, 4));
			configure(n_sel, 16'($urandom_range(0, 60)), 17'($urandom_range(0, 60)),
				17'($urandom_range(20, 180)), 16'($urandom_range(0, 4)),
				20'($urandom_range(0, 6)), 24'($urandom_range(0, 200)));
			run_items($urandom_range(25, 40), ($urandom_range(0, 3) == 0),
				$urandom_range(3, 40));
		end

		// Longest batch gap: the sequencer parks after its first result.
		configure(4'd1, 16'd40, 17'd0, 17'd131071, 16'd0, 20'hFFFFF, 24'd100);
		run_items(40, 1'b0, 30);

		repeat (4) @(negedge clk);
		if (sb.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
